// ===== hw/rtl/sskd_pkg.sv =====
// Shared types and constants of the sorted key store with delete.
`timescale 1ns / 1ps

package sskd_pkg;

  // Field widths of the channel payloads.
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned PAGE_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SENTINEL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ORDER    = 2'd3;

  // The most negative key marks padding and is never stored.
  localparam logic signed [KEY_W-1:0] SENTINEL_KEY = 32'sh8000_0000;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SCAN,
    ST_SHIFT,
    ST_TAIL_RD,
    ST_TAIL_WAIT
  } sskd_state_e;

endpackage

// ===== hw/rtl/sskd_in_if.sv =====
// Request channel: operation code and key.
`timescale 1ns / 1ps

interface sskd_in_if;
  import sskd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

// ===== hw/rtl/sskd_out_if.sv =====
// Response channel: removed count, entry count, page count and status.
`timescale 1ns / 1ps

interface sskd_out_if;
  import sskd_pkg::*;

  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  removed_count;
  logic [COUNT_W-1:0]  entry_count;
  logic [PAGE_W-1:0]   page_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, removed_count, entry_count, page_count, status,
                  input ready);
  modport sink   (input valid, removed_count, entry_count, page_count, status,
                  output ready);
endinterface

// ===== hw/rtl/sskd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sskd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sorted_store_key_delete.sv =====
// Sorted paged key store with append and delete of every copy of a key.
`timescale 1ns / 1ps

// The block holds up to ENTRIES_PER_PAGE * MAX_PAGES signed keys in ascending
// order in one RAM with a single read and a single write port. An append
// checks the key against the capacity, the padding sentinel and the last
// stored key, then writes it behind the tail. A delete of the sentinel key
// is refused at once; any other delete runs a sequencer around the RAM read
// port: a binary search, a scan over the run of equal keys and, if keys were
// removed, a shift of every later key down by the run length and a refetch
// of the new last key, if any is left. The block accepts no request while a
// delete runs. The page count is tracked incrementally, so no division is
// needed, and the RAM needs no clearing after reset. A response is held in an
// output register, and the next request is taken in the cycle that response
// is consumed.
module sorted_store_key_delete #(
  parameter int unsigned ENTRIES_PER_PAGE = 256,
  parameter int unsigned MAX_PAGES        = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sskd_in_if.sink    in_i,
  sskd_out_if.source out_o
);
  import sskd_pkg::*;

  localparam int unsigned Depth = ENTRIES_PER_PAGE * MAX_PAGES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned OW    = $clog2(ENTRIES_PER_PAGE);
  localparam int unsigned PW    = $clog2(MAX_PAGES + 1);

  localparam logic [CW-1:0] DepthC  = CW'(Depth);
  localparam logic [OW-1:0] OffLast = OW'(ENTRIES_PER_PAGE - 1);

  sskd_state_e state_q, state_d;

  logic [CW-1:0]  count_q, count_d;
  logic [PW-1:0]  pg_q, pg_d;
  logic [OW-1:0]  off_q, off_d;
  logic signed [KEY_W-1:0] last_key_q, last_key_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]  first_q, first_d, last_q, last_d;
  logic [CW-1:0]  ptr_q, ptr_d, wptr_q, wptr_d;
  logic           pend_q, pend_d;
  logic           out_valid_q, out_valid_d;

  logic [CW-1:0]       res_removed_q, removed_d;
  logic [CW-1:0]       res_count_q;
  logic [PW-1:0]       res_pages_q;
  logic [STATUS_W-1:0] res_status_q, status_d;
  logic                load_res;

  logic [CW-1:0]           mid;
  logic                    accept;
  logic                    issue;
  logic                    mismatch;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [KEY_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [KEY_W-1:0]        ram_rdata;
  logic signed [KEY_W-1:0] rd_key;

  // Key storage.
  sskd_ram #(
    .WIDTH (KEY_W),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata;
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign accept = in_i.valid && in_i.ready;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);

  // Sequencer: next state, datapath updates and RAM control.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pg_d        = pg_q;
    off_d       = off_q;
    last_key_d  = last_key_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    first_d     = first_q;
    last_d      = last_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    removed_d   = '0;
    status_d    = STATUS_OK;
    load_res    = 1'b0;
    issue       = 1'b0;
    mismatch    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = in_i.key;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.func == FUNC_APPEND) begin
            load_res    = 1'b1;
            out_valid_d = 1'b1;
            if (count_q == DepthC) begin
              status_d = STATUS_FULL;
            end else if (in_i.key == SENTINEL_KEY) begin
              status_d = STATUS_SENTINEL;
            end else if ((count_q != '0) && (in_i.key < last_key_q)) begin
              status_d = STATUS_ORDER;
            end else begin
              // Store behind the tail and advance the page bookkeeping.
              ram_we     = 1'b1;
              count_d    = count_q + 1'b1;
              last_key_d = in_i.key;
              if (count_q == '0) begin
                pg_d  = PW'(1);
                off_d = '0;
              end else if (off_q == OffLast) begin
                pg_d  = pg_q + 1'b1;
                off_d = '0;
              end else begin
                off_d = off_q + 1'b1;
              end
            end
          end else if (in_i.key == SENTINEL_KEY) begin
            load_res    = 1'b1;
            out_valid_d = 1'b1;
            status_d    = STATUS_SENTINEL;
          end else begin
            key_d   = in_i.key;
            lo_d    = '0;
            hi_d    = count_q;
            state_d = ST_SEARCH;
          end
        end
      end

      // Binary search for the first key not less than the request.
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid[AW-1:0];
          mid_d     = mid;
          state_d   = ST_COMPARE;
        end else begin
          first_d = lo_q;
          last_d  = lo_q;
          ptr_d   = lo_q;
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end

      ST_COMPARE: begin
        if (rd_key < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SEARCH;
      end

      // Scan the run of equal keys, one read in flight each cycle.
      ST_SCAN: begin
        mismatch = pend_q && (rd_key != key_q);
        issue    = !mismatch && (ptr_q < count_q);
        if (issue) begin
          ram_raddr = ptr_q[AW-1:0];
          ptr_d     = ptr_q + 1'b1;
        end
        pend_d = issue;
        if (pend_q && !mismatch) begin
          // One more key leaves the store.
          last_d = last_q + 1'b1;
          if ((pg_q == PW'(1)) && (off_q == '0)) begin
            pg_d = '0;
          end else if (off_q == '0) begin
            pg_d  = pg_q - 1'b1;
            off_d = OffLast;
          end else begin
            off_d = off_q - 1'b1;
          end
        end
        if (mismatch || (!pend_q && (ptr_q >= count_q))) begin
          pend_d = 1'b0;
          if (last_q == first_q) begin
            load_res    = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            ptr_d   = last_q;
            wptr_d  = first_q;
            state_d = ST_SHIFT;
          end
        end
      end

      // Move every later key down over the removed run.
      ST_SHIFT: begin
        issue = ptr_q < count_q;
        if (issue) begin
          ram_raddr = ptr_q[AW-1:0];
          ptr_d     = ptr_q + 1'b1;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_q[AW-1:0];
          ram_wdata = ram_rdata;
          wptr_d    = wptr_q + 1'b1;
        end
        pend_d = issue;
        if (!issue && !pend_q) begin
          count_d = count_q - (last_q - first_q);
          state_d = ST_TAIL_RD;
        end
      end

      // Refetch the last key for later order checks.
      ST_TAIL_RD: begin
        if (count_q == '0) begin
          removed_d   = last_q - first_q;
          load_res    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          ram_raddr = count_q[AW-1:0] - 1'b1;
          state_d   = ST_TAIL_WAIT;
        end
      end

      ST_TAIL_WAIT: begin
        last_key_d  = rd_key;
        removed_d   = last_q - first_q;
        load_res    = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pg_q        <= '0;
      off_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pg_q        <= pg_d;
      off_q       <= off_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and response registers.
  always_ff @(posedge clk_i) begin
    last_key_q <= last_key_d;
    key_q      <= key_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    first_q    <= first_d;
    last_q     <= last_d;
    ptr_q      <= ptr_d;
    wptr_q     <= wptr_d;
    if (load_res) begin
      res_removed_q <= removed_d;
      res_count_q   <= count_d;
      res_pages_q   <= pg_d;
      res_status_q  <= status_d;
    end
  end

  // Response fields, zero-extended or truncated to their channel widths.
  logic [CW+COUNT_W-1:0] removed_ext;
  logic [CW+COUNT_W-1:0] count_ext;
  logic [PW+PAGE_W-1:0]  pages_ext;

  assign removed_ext = {{COUNT_W{1'b0}}, res_removed_q};
  assign count_ext   = {{COUNT_W{1'b0}}, res_count_q};
  assign pages_ext   = {{PAGE_W{1'b0}}, res_pages_q};

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_count = removed_ext[COUNT_W-1:0];
  assign out_o.entry_count   = count_ext[COUNT_W-1:0];
  assign out_o.page_count    = pages_ext[PAGE_W-1:0];
  assign out_o.status        = res_status_q;

endmodule
